// File: sv/table_waveform_oscillator_defines.svh
// ----------------------------------------------------------------------------
// Table waveform oscillator assertion macros
// Shared property wrappers for the oscillator checks, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef TABLE_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define TABLE_WAVEFORM_OSCILLATOR_DEFINES_SVH

// Check that is off while reset is asserted
`define TBWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that also holds while reset is asserted
`define TBWO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/tbwo_pkg.sv
// ----------------------------------------------------------------------------
// Table waveform oscillator package
// Register codes, reset values, field widths and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tbwo_pkg;

  // Default sizes
  localparam int unsigned INDEX_BITS_DEF  = 10;
  localparam int unsigned PHASE_BITS_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Register field widths
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned WAVE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_TONE_FREQ   = 2'd1,
    CFG_WAVE_SELECT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // Waveform codes
  typedef enum logic [WAVE_W-1:0] {
    WAVE_NONE   = 2'd0,
    WAVE_SINE   = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_e;

  // Reset configuration: 44.1 kHz, 1 kHz tone, sine
  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(44100);
  localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(256000);
  localparam wave_e             WAVE_RST = WAVE_SINE;

  // Sine recurrence: 60-bit fixed point, rotation by 2*pi/1024
  localparam int unsigned FIX_BITS = 60;
  localparam longint ROT_COS = 64'sd99998117;
  localparam longint ROT_SIN = 64'sd613588;
  localparam longint ROT_DEN = 64'sd100000000;

  // v * c / ROT_DEN, split so the product stays inside 64 bits
  function automatic longint mul_ratio(input longint v, input longint c);
    longint q;
    longint r;
    q = v / ROT_DEN;
    r = v % ROT_DEN;
    return q * c + (r * c) / ROT_DEN;
  endfunction

endpackage

`default_nettype wire

// File: sv/tbwo_step_div.sv
// ----------------------------------------------------------------------------
// Phase step divider
// Restoring divider, one quotient bit per cycle: step = (tone << (P-8)) / rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tbwo_step_div #(
  parameter int unsigned PHASE_BITS = tbwo_pkg::PHASE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tbwo_pkg::RATE_W-1:0] rate_i,
  input  wire logic [tbwo_pkg::FREQ_W-1:0] tone_i,
  output logic                             busy_o,
  output logic [PHASE_BITS-1:0]            step_o
);
  import tbwo_pkg::*;

  localparam int unsigned NUM_W = FREQ_W + PHASE_BITS - 8;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_W-1:0]    num_q;
  logic [RATE_W-1:0]   den_q;
  logic [RATE_W-1:0]   rem_q;
  logic [PHASE_BITS-1:0] quo_q;

  logic [RATE_W:0]     trial;
  logic                qbit;
  logic [RATE_W:0]     diff;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  // Control: busy and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (rate_i != '0);
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: a zero rate gives a zero step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {tone_i, {(PHASE_BITS-8){1'b0}}};
      den_q <= rate_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo_q <= {quo_q[PHASE_BITS-2:0], qbit};
    end
  end

  assign busy_o = busy_q;
  assign step_o = quo_q;

endmodule

`default_nettype wire

// File: sv/tbwo_sine_rom.sv
// ----------------------------------------------------------------------------
// Sine table ROM
// One full sine period at INDEX_BITS = 10, built at elaboration from a fixed
// rotation recurrence; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tbwo_sine_rom #(
  parameter int unsigned INDEX_BITS  = tbwo_pkg::INDEX_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = tbwo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rd_en_i,
  input  wire logic [INDEX_BITS-1:0]  rd_addr_i,
  output logic [SAMPLE_BITS-1:0]      rd_data_o
);
  import tbwo_pkg::*;

  localparam int unsigned ROM_SIZE   = 1 << INDEX_BITS;
  localparam int unsigned SINE_SHIFT = FIX_BITS - (SAMPLE_BITS - 1);
  localparam longint      SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint      SAMPLE_MIN = -(longint'(1) << (SAMPLE_BITS - 1));

  // Round to nearest, ties away from zero, then saturate
  function automatic logic [SAMPLE_BITS-1:0] round_sample(input longint y);
    longint unsigned m;
    longint unsigned r;
    longint          s;
    m = (y < 0) ? longint'(-y) : y;
    r = (m + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT;
    s = (y < 0) ? -longint'(r) : longint'(r);
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    if (s < SAMPLE_MIN) s = SAMPLE_MIN;
    return s[SAMPLE_BITS-1:0];
  endfunction

  // Rotate (1, 0) once per entry; entry i is y after i rotations
  function automatic logic [ROM_SIZE-1:0][SAMPLE_BITS-1:0] build_sine();
    logic [ROM_SIZE-1:0][SAMPLE_BITS-1:0] tbl;
    longint x;
    longint y;
    longint nx;
    longint ny;
    tbl = '0;
    x   = longint'(1) << FIX_BITS;
    y   = 0;
    for (int i = 0; i < ROM_SIZE; i++) begin
      tbl[i] = round_sample(y);
      nx = mul_ratio(x, ROT_COS) - mul_ratio(y, ROT_SIN);
      ny = mul_ratio(y, ROT_COS) + mul_ratio(x, ROT_SIN);
      x  = nx;
      y  = ny;
    end
    return tbl;
  endfunction

  localparam logic [ROM_SIZE-1:0][SAMPLE_BITS-1:0] SINE_TABLE = build_sine();

  logic [SAMPLE_BITS-1:0] rd_data_q;

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= SINE_TABLE[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: sv/table_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// Table waveform oscillator
// Phase accumulator oscillator with sine table, square and sawtooth outputs.
// ----------------------------------------------------------------------------
// Takes one tick item per cycle unless held off by a step update or output
// back-pressure; its sample follows in the cycle after it is accepted, from
// the registered sine table read and result register. A tick gives no sample,
// and the phase holds, while the sample rate or the tone is zero or the wave
// select is none. After reset and after each write to one of the three
// registers the phase step is recomputed by a bit-serial divider, during
// which no tick item is accepted. Register writes are taken in every cycle.
`default_nettype none

`include "table_waveform_oscillator_defines.svh"

module table_waveform_oscillator #(
  parameter int unsigned INDEX_BITS  = tbwo_pkg::INDEX_BITS_DEF,
  parameter int unsigned PHASE_BITS  = tbwo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = tbwo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // register write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tbwo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tbwo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // tick items
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            sample_tick_i,
  // sample items
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_value_o
);
  import tbwo_pkg::*;

  localparam int unsigned SAW_SHIFT = (SAMPLE_BITS >= INDEX_BITS) ?
                                      SAMPLE_BITS - INDEX_BITS : 0;

  // Configuration registers
  logic [RATE_W-1:0] rate_q;
  logic [FREQ_W-1:0] tone_q;
  wave_e             wave_q;
  logic              recalc_q;

  logic              cfg_fire;
  logic              cfg_known;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_known   = (cfg_index_i != CFG_UNUSED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RATE_RST;
      tone_q   <= FREQ_RST;
      wave_q   <= WAVE_RST;
      recalc_q <= 1'b1;
    end else begin
      recalc_q <= cfg_fire && cfg_known;
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_SAMPLE_RATE: rate_q <= cfg_data_i[RATE_W-1:0];
          CFG_TONE_FREQ:   tone_q <= cfg_data_i[FREQ_W-1:0];
          CFG_WAVE_SELECT: wave_q <= wave_e'(cfg_data_i[WAVE_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // Step divider, restarted the cycle after a write to a known register
  logic                  div_busy;
  logic [PHASE_BITS-1:0] phase_step;

  tbwo_step_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_step_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (recalc_q),
    .rate_i  (rate_q),
    .tone_i  (tone_q),
    .busy_o  (div_busy),
    .step_o  (phase_step)
  );

  // Handshake and firing condition
  logic                  out_valid_q;
  logic                  in_fire;
  logic                  gen_fire;
  logic                  enabled;

  assign enabled    = (rate_q != '0) && (tone_q != '0) && (wave_q != WAVE_NONE);
  assign in_ready_o = !recalc_q && !div_busy && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign gen_fire   = in_fire && sample_tick_i && enabled;

  // Phase accumulator
  logic [PHASE_BITS-1:0] phase_q;
  logic [INDEX_BITS-1:0] index;

  assign index = phase_q[PHASE_BITS-1 -: INDEX_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (gen_fire) begin
      phase_q <= phase_q + phase_step;
    end
  end

  // Sine table
  logic [SAMPLE_BITS-1:0] sine_data;

  tbwo_sine_rom #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sine_rom (
    .clk_i     (clk_i),
    .rd_en_i   (gen_fire),
    .rd_addr_i (index),
    .rd_data_o (sine_data)
  );

  // Square and sawtooth from the index; offset by -half scale flips the MSB
  logic [INDEX_BITS-1:0]  saw_base;
  logic [SAMPLE_BITS-1:0] saw_value;
  logic [SAMPLE_BITS-1:0] square_value;

  assign saw_base = {~index[INDEX_BITS-1], index[INDEX_BITS-2:0]};

  if (SAMPLE_BITS >= INDEX_BITS) begin : g_saw_wide
    assign saw_value = SAMPLE_BITS'(saw_base) << SAW_SHIFT;
  end else begin : g_saw_narrow
    assign saw_value = saw_base[INDEX_BITS-1 -: SAMPLE_BITS];
  end

  assign square_value = index[INDEX_BITS-1] ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                            : {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Result register
  logic                   sel_sine_q;
  logic [SAMPLE_BITS-1:0] alt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (gen_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_fire) begin
      sel_sine_q <= (wave_q == WAVE_SINE);
      alt_q      <= (wave_q == WAVE_SQUARE) ? square_value : saw_value;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sel_sine_q ? sine_data : alt_q;

  // Checks
  `TBWO_ASSERT(a_no_item_while_div, in_fire |-> !div_busy && !recalc_q, "item taken during step update")
  `TBWO_ASSERT(a_result_from_fire, out_valid_q && !$past(out_valid_q) |-> $past(gen_fire), "sample without tick")
  `TBWO_ASSERT(a_phase_holds, !gen_fire |=> $stable(phase_q), "phase moved without a sample")
  `TBWO_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_q && !in_fire, "activity in reset")

endmodule

`default_nettype wire

// File: dv/tb_table_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// Table waveform oscillator testbench
// Drives tick items and register writes, predicts every sample from a local
// copy of the phase accumulator, step divider and sine table, and checks the
// sample stream in order under random idling and output back-pressure.
// ----------------------------------------------------------------------------

module tb_table_waveform_oscillator;

  import tbwo_pkg::*;

  localparam int unsigned IDX_W   = INDEX_BITS_DEF;
  localparam int unsigned PHASE_W = PHASE_BITS_DEF;
  localparam int unsigned SMP_W   = SAMPLE_BITS_DEF;
  localparam int unsigned LUT_N   = 1 << IDX_W;

  // Sine recurrence in 60-bit fixed point, one rotation step per entry
  localparam int unsigned FRAC_W    = 60;
  localparam int unsigned ROUND_SH  = FRAC_W - (SMP_W - 1);
  localparam longint      COS_NUM   = 64'sd99998117;
  localparam longint      SIN_NUM   = 64'sd613588;
  localparam longint      RATIO_DEN = 64'sd100000000;
  localparam longint      SMP_TOP   = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint      SMP_BOT   = -(64'sd1 <<< (SMP_W - 1));

  localparam int unsigned STALL_CYCLES = 64;
  localparam int unsigned DRAIN_GAP    = 4;
  localparam int unsigned IDLE_LIMIT   = 4000;

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  sample_tick_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic signed [SMP_W-1:0] sample_value_o;

  table_waveform_oscillator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_tick_i (sample_tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_value_o(sample_value_o)
  );

  // Oscillator state as the block should hold it
  logic [RATE_W-1:0]       cur_rate;
  logic [FREQ_W-1:0]       cur_freq;
  wave_e                   cur_wave;
  logic [PHASE_W-1:0]      phase_acc;
  logic [PHASE_W-1:0]      phase_inc;
  logic signed [SMP_W-1:0] sine_lut [LUT_N];

  logic signed [SMP_W-1:0] expected_samples [$];
  int  samples_predicted = 0;
  int  error_count       = 0;
  int  sender_idle_pct   = 0;
  int  receiver_idle_pct = 0;
  bit  hold_output       = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // v * num / RATIO_DEN truncated toward zero, wide enough to never overflow
  function automatic longint scale_ratio(input longint v, input longint num);
    logic signed [127:0] prod;
    prod = v;
    prod = prod * num;
    prod = prod / RATIO_DEN;
    return longint'(prod);
  endfunction

  // Round to nearest, ties away from zero, then saturate to the sample range
  function automatic logic signed [SMP_W-1:0] round_sample(input longint y);
    longint unsigned mag;
    longint          rnd;
    mag = (y < 0) ? -y : y;
    rnd = longint'((mag + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH);
    if (y < 0) rnd = -rnd;
    if (rnd > SMP_TOP) rnd = SMP_TOP;
    if (rnd < SMP_BOT) rnd = SMP_BOT;
    return SMP_W'(rnd);
  endfunction

  function automatic void build_sine_lut();
    longint x;
    longint y;
    longint nx;
    x = 64'sd1 <<< FRAC_W;
    y = 0;
    for (int i = 0; i < LUT_N; i++) begin
      sine_lut[i] = round_sample(y);
      nx = scale_ratio(x, COS_NUM) - scale_ratio(y, SIN_NUM);
      y  = scale_ratio(y, COS_NUM) + scale_ratio(x, SIN_NUM);
      x  = nx;
    end
  endfunction

  // floor(freq * 2^PHASE_W / 256 / rate) mod 2^PHASE_W, zero rate gives zero
  function automatic logic [PHASE_W-1:0] phase_increment(input logic [RATE_W-1:0] rate,
                                                         input logic [FREQ_W-1:0] freq);
    longint unsigned scaled;
    if (rate == '0) return '0;
    scaled = longint'(freq) << (PHASE_W - 8);
    return PHASE_W'(scaled / rate);
  endfunction

  function automatic void apply_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SAMPLE_RATE: cur_rate = data[RATE_W-1:0];
      CFG_TONE_FREQ:   cur_freq = data[FREQ_W-1:0];
      CFG_WAVE_SELECT: cur_wave = wave_e'(data[WAVE_W-1:0]);
      default:         return;
    endcase
    phase_inc = phase_increment(cur_rate, cur_freq);
  endfunction

  // One accepted tick: if it gives a sample, queue it and advance the phase
  function automatic void predict_tick(input logic tick);
    logic [IDX_W-1:0]        idx;
    logic signed [SMP_W-1:0] val;
    if (!tick || cur_rate == '0 || cur_freq == '0 || cur_wave == WAVE_NONE) return;
    idx = phase_acc[PHASE_W-1 -: IDX_W];
    case (cur_wave)
      WAVE_SINE:   val = sine_lut[idx];
      WAVE_SQUARE: val = idx[IDX_W-1] ? SMP_W'(SMP_TOP) : SMP_W'(SMP_BOT);
      default:     val = SMP_W'({idx, {(SMP_W - IDX_W){1'b0}}}) - SMP_W'(SMP_BOT);
    endcase
    expected_samples.push_back(val);
    samples_predicted++;
    phase_acc = phase_acc + phase_inc;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one tick item, idling first at the sender's current rate
  task automatic send_tick(input logic tick);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_tick_i <= tick;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tick(tick);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering ticks and let every pending sample come out
  task automatic wait_for_samples();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Output ready: random idling, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sample checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic signed [SMP_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected sample %0d", $time, sample_value_o);
      end else begin
        want = expected_samples.pop_front();
        if (sample_value_o !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: sample_value expected %0d, got %0d", $time, want, sample_value_o);
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on any channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: 1 kHz sine at 44.1 kHz, with a low tick between
  task automatic test_reset_defaults();
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Square across both halves, then a slow sawtooth
  task automatic test_waveforms();
    wait_for_samples();
    write_register(CFG_SAMPLE_RATE, 24'd1);
    write_register(CFG_TONE_FREQ, 24'h80);
    write_register(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SQUARE));
    repeat (3) send_tick(1'b1);
    wait_for_samples();
    write_register(CFG_TONE_FREQ, 24'd1);
    write_register(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SAW));
    repeat (3) send_tick(1'b1);
  endtask

  // Largest tone at the lowest and highest rates; the first wraps the step
  task automatic test_extremes();
    wait_for_samples();
    write_register(CFG_TONE_FREQ, 24'hFFFFFF);
    repeat (2) send_tick(1'b1);
    wait_for_samples();
    write_register(CFG_SAMPLE_RATE, 24'h03FFFF);
    repeat (2) send_tick(1'b1);
  endtask

  // Ignored index, masked values, and every way of disabling output
  task automatic test_disabled_output();
    wait_for_samples();
    write_register(CFG_UNUSED, 24'hFFFFFF);
    send_tick(1'b1);
    wait_for_samples();
    write_register(CFG_SAMPLE_RATE, 24'hFC0000);
    send_tick(1'b1);
    wait_for_samples();
    write_register(CFG_SAMPLE_RATE, 24'h1C0000 | 24'd48000);
    write_register(CFG_TONE_FREQ, 24'd0);
    send_tick(1'b1);
    wait_for_samples();
    write_register(CFG_TONE_FREQ, 24'd256000);
    write_register(CFG_WAVE_SELECT, 24'hFFFFFC);
    send_tick(1'b1);
    wait_for_samples();
    write_register(CFG_WAVE_SELECT, 24'hFFFFFD);
    repeat (2) send_tick(1'b1);
  endtask

  // Long output hold-off while ticks keep coming, then a full drain
  task automatic test_backpressure();
    wait_for_samples();
    write_register(CFG_TONE_FREQ, 24'd112640);
    write_register(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SAW));
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_output       = 1'b1;
    repeat (30) send_tick(1'b1);
    wait_for_samples();
    repeat (10) send_tick(1'b1);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_rate();
    case ($urandom_range(15))
      0:       return {6'($urandom), 18'd0};
      1:       return 24'd1;
      2:       return {6'($urandom), 18'h3FFFF};
      3:       return 24'd44100;
      4:       return 24'd48000;
      5:       return 24'($urandom);
      default: return 24'($urandom_range(2000, 200000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_tone();
    case ($urandom_range(15))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'd1;
      3, 4:    return 24'($urandom);
      default: return 24'($urandom_range(256 * 20, 256 * 20000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_wave();
    wave_e w;
    w = ($urandom_range(15) == 0) ? WAVE_NONE : wave_e'($urandom_range(1, 3));
    return {22'($urandom), w};
  endfunction

  // Random settings, each followed by a burst of ticks
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int target);
    int goal;
    goal              = samples_predicted + target;
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    while (samples_predicted < goal) begin
      wait_for_samples();
      write_register(CFG_SAMPLE_RATE, random_rate());
      write_register(CFG_TONE_FREQ, random_tone());
      write_register(CFG_WAVE_SELECT, random_wave());
      if ($urandom_range(3) == 0) write_register(CFG_UNUSED, 24'($urandom));
      repeat ($urandom_range(16, 80)) send_tick($urandom_range(7) != 0);
    end
  endtask

  // Sequence
  initial begin
    build_sine_lut();
    cur_rate  = RATE_RST;
    cur_freq  = FREQ_RST;
    cur_wave  = WAVE_RST;
    phase_acc = '0;
    phase_inc = phase_increment(cur_rate, cur_freq);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_waveforms();
    test_extremes();
    test_disabled_output();
    test_backpressure();
    test_random_traffic(36, 69, 380);
    test_random_traffic(69, 36, 380);
    test_random_traffic(0, 0, 380);

    wait_for_samples();
    repeat (16) @(posedge clk_i);
    if (error_count == 0 && expected_samples.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
